// ===== hw/rtl/rfa_pkg.sv =====
// Shared types and codes for the ring frame allocator.
// No dependencies; used by ring_frame_allocator.
package rfa_pkg;

  typedef enum logic [1:0] {
    KindAlloc   = 2'd0,
    KindDiscard = 2'd1,
    KindWrap    = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StNoRoom   = 2'd1,
    StTooLarge = 2'd2
  } status_e;

  localparam int unsigned OffW  = 16;
  localparam int unsigned SizeW = 17;

  typedef struct packed {
    logic [1:0]      kind;
    logic [OffW-1:0] frame_size;
  } req_t;

  typedef struct packed {
    logic [1:0]      status;
    logic [OffW-1:0] offset;
    logic            marker_written;
    logic [OffW-1:0] marker_offset;
  } rsp_t;

endpackage

// ===== hw/rtl/rfa_stream_if.sv =====
// Valid/ready stream interface carrying one payload per transfer.
// Payload type is a parameter; the allocator uses rfa_pkg::req_t and rsp_t.
interface rfa_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/ring_frame_allocator.sv =====
// Ring frame allocator: read/write offsets of a circular byte buffer.
// Depends on rfa_pkg and rfa_stream_if.
//
// Usage:
//   req_i carries one request per transfer: kind (allocate, discard,
//   wraparound) and frame_size in bytes, rounded up to ALIGN_BYTES.
//   rsp_o returns exactly one result per request: status (ok, no room,
//   too large), the frame start or new read offset, and a wrap marker
//   flag with the old write offset when an allocation jumps to the head.
//   cfg_we_i/cfg_wdata_i write buffer_size; write only while idle.
// Timing:
//   A request is latched in an input register, evaluated against the
//   offset registers in one pass, and lands in the result register,
//   which drives rsp_o. One request per cycle is sustained while
//   rsp_o.ready stays high; the only loop is the offset update.
// Reset:
//   read and write offsets go to zero, buffer_size to 65536, no result.
// Stall:
//   When rsp_o.ready is low the result holds; one more request is taken
//   into the input register, then req_i.ready drops until space frees.
module ring_frame_allocator #(
  parameter int unsigned BUF_BYTES   = 65536,
  parameter int unsigned ALIGN_BYTES = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [rfa_pkg::SizeW-1:0]   cfg_wdata_i,
  rfa_stream_if.sink                  req_i,
  rfa_stream_if.source                rsp_o
);

  localparam int unsigned OffW  = rfa_pkg::OffW;
  localparam int unsigned SizeW = rfa_pkg::SizeW;
  localparam int unsigned LimInt = (BUF_BYTES > 65536) ? 65536 : BUF_BYTES;
  localparam logic [SizeW-1:0] LimSize   = SizeW'(LimInt);
  localparam logic [SizeW-1:0] AlignMask = SizeW'(ALIGN_BYTES - 1);

  // offset advance with wrap to zero at or past the buffer end
  function automatic logic [OffW-1:0] step_off(logic [SizeW-1:0] p,
                                               logic [SizeW-1:0] d,
                                               logic [SizeW-1:0] s);
    logic [SizeW:0] q;
    q = {1'b0, p} + {1'b0, d};
    return (q >= {1'b0, s}) ? '0 : q[OffW-1:0];
  endfunction

  logic [SizeW-1:0] buf_size_q;
  logic [OffW-1:0]  rd_off_q, rd_off_d;
  logic [OffW-1:0]  wr_off_q, wr_off_d;
  logic             in_v_q;
  rfa_pkg::req_t    in_q;
  logic             out_v_q;
  rfa_pkg::rsp_t    out_q, out_d;
  logic             adv;

  // stage 2 moves when the result slot is free or being drained
  assign adv         = !out_v_q || rsp_o.ready;
  assign req_i.ready = !in_v_q || adv;
  assign rsp_o.valid = out_v_q;
  assign rsp_o.payload = out_q;

  logic [SizeW-1:0] eff_size;
  logic [SizeW-1:0] a_size;
  logic [SizeW-1:0] r_ext, w_ext;
  logic [SizeW-1:0] gap;
  logic [SizeW-1:0] tail_free;
  logic             too_large;

  always_comb begin
    eff_size  = ((buf_size_q > LimSize) ? LimSize : buf_size_q) & ~AlignMask;
    a_size    = ({1'b0, in_q.frame_size} + AlignMask) & ~AlignMask;
    r_ext     = {1'b0, rd_off_q};
    w_ext     = {1'b0, wr_off_q};
    gap       = r_ext - w_ext;
    tail_free = (w_ext < eff_size) ? (eff_size - w_ext) : '0;
    too_large = ({1'b0, a_size} + (SizeW+1)'(1)) >= {1'b0, eff_size};

    rd_off_d = rd_off_q;
    wr_off_d = wr_off_q;
    out_d.status         = rfa_pkg::StOk;
    out_d.offset         = '0;
    out_d.marker_written = 1'b0;
    out_d.marker_offset  = '0;

    case (in_q.kind)
      rfa_pkg::KindAlloc: begin
        if (too_large) begin
          out_d.status = rfa_pkg::StTooLarge;
        end else if (rd_off_q == wr_off_q) begin
          // empty buffer: rewind both offsets
          rd_off_d = '0;
          wr_off_d = step_off('0, a_size, eff_size);
        end else if (rd_off_q > wr_off_q) begin
          if (a_size < gap) begin
            wr_off_d     = step_off(w_ext, a_size, eff_size);
            out_d.offset = wr_off_q;
          end else begin
            out_d.status = rfa_pkg::StNoRoom;
          end
        end else if (a_size < tail_free) begin
          wr_off_d     = step_off(w_ext, a_size, eff_size);
          out_d.offset = wr_off_q;
        end else if (a_size < r_ext) begin
          // head segment: marker at the old write offset
          wr_off_d             = step_off('0, a_size, eff_size);
          out_d.marker_written = 1'b1;
          out_d.marker_offset  = wr_off_q;
        end else begin
          out_d.status = rfa_pkg::StNoRoom;
        end
      end
      rfa_pkg::KindDiscard: begin
        rd_off_d     = step_off(r_ext, a_size, eff_size);
        out_d.offset = rd_off_d;
      end
      rfa_pkg::KindWrap: begin
        rd_off_d = '0;
      end
      default: begin
        out_d.offset = rd_off_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_size_q <= SizeW'(65536);
      rd_off_q   <= '0;
      wr_off_q   <= '0;
      in_v_q     <= 1'b0;
      out_v_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        buf_size_q <= cfg_wdata_i;
      end
      if (req_i.ready) begin
        in_v_q <= req_i.valid;
      end
      if (adv) begin
        out_v_q <= in_v_q;
        if (in_v_q) begin
          rd_off_q <= rd_off_d;
          wr_off_q <= wr_off_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.ready && req_i.valid) begin
      in_q <= req_i.payload;
    end
    if (adv && in_v_q) begin
      out_q <= out_d;
    end
  end

  a_too_large_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.payload.status == rfa_pkg::StTooLarge)
      |-> (rsp_o.payload.offset == '0 && !rsp_o.payload.marker_written))
    else $error("too-large result carries an offset or marker");

  a_marker_at_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.payload.marker_written)
      |-> (rsp_o.payload.offset == '0 && rsp_o.payload.status == rfa_pkg::StOk))
    else $error("wrap marker without a head allocation");

  a_wrap_clears_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && in_v_q && in_q.kind == rfa_pkg::KindWrap) |=> (rd_off_q == '0))
    else $error("wraparound did not clear the read offset");

  a_reject_keeps_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && in_v_q && out_d.status != rfa_pkg::StOk)
      |=> ($stable(rd_off_q) && $stable(wr_off_q)))
    else $error("rejected allocation changed the offsets");

endmodule
